>>> rtl/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared widths, codes and controller/datapath signal groups for the sorted
// timer expiry queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int STQ_NUM_TIMERS = 16;
  localparam int MAX_OUT        = 16;
  localparam int CMD_W          = 2;
  localparam int ID_W           = 4;
  localparam int DELAY_W        = 16;
  localparam int TOKEN_W        = 32;
  localparam int TICK_W         = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ARMED    = 2'd0,
    ST_REJECT   = 2'd1,
    ST_DISARMED = 2'd2,
    ST_EXPIRED  = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    tick;
    logic    drop_id;
    logic    drop_head;
    logic    insert;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
  } stq_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic armed;
    logic full;
    logic delay_zero;
    logic nonempty;
    logic has_two;
    logic head_due;
    logic next_due;
    logic out_free;
  } stq_sts_t;

endpackage

>>> rtl/stq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface stq_in_if;
  logic                         valid;
  logic                         ready;
  logic [stq_pkg::CMD_W-1:0]    cmd;
  logic [stq_pkg::ID_W-1:0]     timer_id;
  logic [stq_pkg::DELAY_W-1:0]  delay;
  logic [stq_pkg::TOKEN_W-1:0]  token;

  modport source (output valid, cmd, timer_id, delay, token, input ready);
  modport sink   (input valid, cmd, timer_id, delay, token, output ready);
endinterface

interface stq_out_if;
  logic                          valid;
  logic                          ready;
  logic [stq_pkg::STATUS_W-1:0]  status;
  logic [stq_pkg::ID_W-1:0]      timer_id_res;
  logic [stq_pkg::TOKEN_W-1:0]   token_res;
  logic                          last;

  modport source (output valid, status, timer_id_res, token_res, last, input ready);
  modport sink   (input valid, status, timer_id_res, token_res, last, output ready);
endinterface

>>> rtl/sorted_timer_expiry_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue
// Up to NUM_TIMERS one-shot timers kept in deadline order; tick, arm, disarm.
// ----------------------------------------------------------------------------
// Words are taken one at a time: in_ch.ready is high only while the sequencer
// is idle, and a word is accepted when valid and ready are both high. A tick
// first advances the tick count, then expires one due timer per step (at most
// 16 per tick), and an expiry step that finds nothing due returns to idle; arm
// is rejected in its check step or otherwise goes on to the insert step, a
// re-arm included, since its old entry is dropped in the check step ahead of
// the insert; disarm has its own step. Each result leaves through one output
// register, so a stalled out_ch holds the sequencer in its current step; an
// idle block still accepts a word while its last result waits. The cell chain
// shifts the entries past a drop or insert point by one position and compares
// every cell's deadline in parallel. Command 3 is dropped.
module sorted_timer_expiry_queue #(
  parameter int NUM_TIMERS = stq_pkg::STQ_NUM_TIMERS
) (
  input logic      clk,
  input logic      rst_n,
  stq_in_if.sink   in_ch,
  stq_out_if.source out_ch
);
  import stq_pkg::*;

  stq_ctl_t ctl;
  stq_sts_t sts;

  // sequencer: owns the handshake and steps each command
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // cell chain, tick count and result register
  stq_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_timer_id      (in_ch.timer_id),
    .in_delay         (in_ch.delay),
    .in_token         (in_ch.token),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_timer_id_res (out_ch.timer_id_res),
    .out_token_res    (out_ch.token_res),
    .out_last         (out_ch.last)
  );

endmodule

>>> rtl/stq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// Command sequencer: accepts a word, steps arm, disarm and expiry sequences.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [stq_pkg::CMD_W-1:0] in_cmd,
  output logic                   in_ready,
  input  stq_pkg::stq_sts_t      sts,
  output stq_pkg::stq_ctl_t      ctl
);
  import stq_pkg::*;

  localparam int NW = $clog2(MAX_OUT + 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXPIRE  = 5'b00010,
    S_ARM_CHK = 5'b00100,
    S_INSERT  = 5'b01000,
    S_DISARM  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          exp_last;

  assign in_ready = (state_r == S_IDLE);

  // final expiry of this tick when no further due entry or the burst cap is hit
  assign exp_last = !(sts.has_two && sts.next_due && (n_r < NW'(MAX_OUT - 1)));

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    ctl             = '0;
    ctl.emit_status = ST_ARMED;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_TICK: begin
              ctl.tick  = 1'b1;
              n_nxt     = '0;
              state_nxt = S_EXPIRE;
            end
            CMD_ARM:    state_nxt = S_ARM_CHK;
            CMD_DISARM: state_nxt = S_DISARM;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXPIRE: begin
        if (!sts.nonempty || !sts.head_due) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_EXPIRED;
          ctl.emit_last   = exp_last;
          ctl.drop_head   = 1'b1;
          n_nxt           = n_r + NW'(1);
          if (exp_last) state_nxt = S_IDLE;
        end
      end
      S_ARM_CHK: begin
        if (sts.delay_zero || (!sts.armed && sts.full)) begin
          if (sts.out_free) begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_REJECT;
            ctl.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          ctl.drop_id = sts.armed;
          state_nxt   = S_INSERT;
        end
      end
      S_INSERT: begin
        if (sts.out_free) begin
          ctl.insert      = 1'b1;
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_ARMED;
          ctl.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DISARM: begin
        if (!sts.armed) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          ctl.drop_id     = 1'b1;
          ctl.emit        = 1'b1;
          ctl.emit_status = ST_DISARMED;
          ctl.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

>>> rtl/stq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted cell chain of armed timers, tick counter and result register.
// ----------------------------------------------------------------------------
module stq_datapath #(
  parameter int NUM_TIMERS = stq_pkg::STQ_NUM_TIMERS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stq_pkg::stq_ctl_t            ctl,
  output stq_pkg::stq_sts_t            sts,
  input  logic [stq_pkg::ID_W-1:0]     in_timer_id,
  input  logic [stq_pkg::DELAY_W-1:0]  in_delay,
  input  logic [stq_pkg::TOKEN_W-1:0]  in_token,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [stq_pkg::STATUS_W-1:0] out_status,
  output logic [stq_pkg::ID_W-1:0]     out_timer_id_res,
  output logic [stq_pkg::TOKEN_W-1:0]  out_token_res,
  output logic                         out_last
);
  import stq_pkg::*;

  localparam int CW = $clog2(NUM_TIMERS + 1);

  logic [TICK_W-1:0]  now_r;
  logic [CW-1:0]      count_r;
  logic [TICK_W-1:0]  dl_r  [NUM_TIMERS];
  logic [ID_W-1:0]    sl_r  [NUM_TIMERS];
  logic [TOKEN_W-1:0] tk_r  [NUM_TIMERS];

  logic [ID_W-1:0]    id_r;
  logic [DELAY_W-1:0] delay_r;
  logic [TOKEN_W-1:0] token_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [TOKEN_W-1:0]  out_token_r;
  logic                out_last_r;

  logic [NUM_TIMERS-1:0] vld, match, hit, due, dmask, drop_incl, ins_before;
  logic [TICK_W-1:0]     new_dl;
  logic                  any_drop;

  assign new_dl   = now_r + TICK_W'(delay_r);
  assign any_drop = ctl.drop_id || ctl.drop_head;

  genvar g;
  for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
    logic [TICK_W-1:0]  diff;
    logic [TICK_W-1:0]  up_dl, dn_dl, dl_nxt;
    logic [ID_W-1:0]    up_sl, dn_sl, sl_nxt;
    logic [TOKEN_W-1:0] up_tk, dn_tk, tk_nxt;

    assign vld[g]   = (CW'(g) < count_r);
    assign match[g] = vld[g] && (sl_r[g] == id_r);
    assign diff     = dl_r[g] - now_r;
    assign due[g]   = (diff == '0) || diff[TICK_W-1];
    assign hit[g]   = vld[g] && (diff > TICK_W'(delay_r));

    if (g == 0) begin : g_head
      assign dmask[g]      = ctl.drop_head || match[g];
      assign drop_incl[g]  = dmask[g];
      assign ins_before[g] = 1'b0;
      assign dn_dl = dl_r[g];
      assign dn_sl = sl_r[g];
      assign dn_tk = tk_r[g];
    end else begin : g_body
      assign dmask[g]      = !ctl.drop_head && match[g];
      assign drop_incl[g]  = drop_incl[g-1] || dmask[g];
      assign ins_before[g] = ins_before[g-1] || hit[g-1];
      assign dn_dl = dl_r[g-1];
      assign dn_sl = sl_r[g-1];
      assign dn_tk = tk_r[g-1];
    end

    if (g == NUM_TIMERS - 1) begin : g_tail
      assign up_dl = dl_r[g];
      assign up_sl = sl_r[g];
      assign up_tk = tk_r[g];
    end else begin : g_mid
      assign up_dl = dl_r[g+1];
      assign up_sl = sl_r[g+1];
      assign up_tk = tk_r[g+1];
    end

    always_comb begin
      dl_nxt = dl_r[g];
      sl_nxt = sl_r[g];
      tk_nxt = tk_r[g];
      if (any_drop && drop_incl[g]) begin
        dl_nxt = up_dl;
        sl_nxt = up_sl;
        tk_nxt = up_tk;
      end else if (ctl.insert) begin
        if (ins_before[g]) begin
          dl_nxt = dn_dl;
          sl_nxt = dn_sl;
          tk_nxt = dn_tk;
        end else if (hit[g] || (CW'(g) == count_r)) begin
          dl_nxt = new_dl;
          sl_nxt = id_r;
          tk_nxt = token_r;
        end
      end
    end

    always_ff @(posedge clk) begin
      dl_r[g] <= dl_nxt;
      sl_r[g] <= sl_nxt;
      tk_r[g] <= tk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r    <= in_timer_id;
      delay_r <= in_delay;
      token_r <= in_token;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= '0;
      count_r <= '0;
    end else begin
      if (ctl.tick) now_r <= now_r + TICK_W'(1);
      if (any_drop) count_r <= count_r - CW'(1);
      else if (ctl.insert) count_r <= count_r + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status_r <= ctl.emit_status;
      out_last_r   <= ctl.emit_last;
      if (ctl.emit_status == ST_EXPIRED) begin
        out_id_r    <= sl_r[0];
        out_token_r <= tk_r[0];
      end else begin
        out_id_r    <= id_r;
        out_token_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_timer_id_res = out_id_r;
  assign out_token_res    = out_token_r;
  assign out_last         = out_last_r;

  always_comb begin
    sts            = '0;
    sts.armed      = |match;
    sts.full       = (count_r >= CW'(NUM_TIMERS));
    sts.delay_zero = (delay_r == '0);
    sts.nonempty   = (count_r != '0);
    sts.has_two    = (count_r > CW'(1));
    sts.head_due   = due[0];
    sts.next_due   = due[1];
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

>>> rtl/stq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks for the sorted timer expiry queue, bound to the top.
// ----------------------------------------------------------------------------
module stq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [stq_pkg::CMD_W-1:0]    in_cmd,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stq_pkg::STATUS_W-1:0] out_status,
  input logic [stq_pkg::ID_W-1:0]     out_timer_id_res,
  input logic [stq_pkg::TOKEN_W-1:0]  out_token_res,
  input logic                         out_last
);
  import stq_pkg::*;

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_timer_id_res) && $stable(out_token_res) && $stable(out_last))
    else $error("result word changed while stalled");

  // a real command keeps the sequencer busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != CMD_RSVD) |=> !in_ready)
    else $error("ready stayed high after a command word");

  // arm and disarm answers are single words
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_EXPIRED) |-> out_last)
    else $error("non-expiry result without last");

  // only expiries carry a token
  a_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_EXPIRED) |-> (out_token_res == '0))
    else $error("token on a non-expiry result");

endmodule

bind sorted_timer_expiry_queue stq_checker u_stq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_cmd           (in_ch.cmd),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_timer_id_res (out_ch.timer_id_res),
  .out_token_res    (out_ch.token_res),
  .out_last         (out_ch.last)
);
